>>> design/olist_pkg.sv
// olist_pkg: shared constants and types for the ordered list engine
// command and status codes, field widths and parameter defaults
// no dependencies
`default_nettype none

package olist_pkg;

  // parameter defaults
  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // field widths fixed by the interface
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IN_W    = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT    = 3'd0,
    CMD_INSERT_AT     = 3'd1,
    CMD_INSERT_SORTED = 3'd2,
    CMD_DELETE        = 3'd3,
    CMD_SEARCH        = 3'd4,
    CMD_CLEAR         = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> design/ordered_list_engine_top.sv
// ordered_list_engine_top: ordered list of signed values held in a single-port-write memory
// one shared compare unit, one memory read port and one write port are stepped by a small sequencer
// depends on olist_pkg
//
// sequence: insert at a position moves the entries from the top down to it up, one memory move
//   per cycle, then writes the new value, then gives the result; sorted insert first scans for
//   its position; delete scans for the value, then moves the entries above it down; search
//   only scans; clear, full insert and unused codes go straight to the result.
// throughput: one request at a time, bounded by the single memory read and write port.
// reset: count, the sequencer state and out_valid clear at once; stored entries keep old contents
//   and are never read above count, so no clearing pass is needed.
`default_nettype none

module ordered_list_engine_top #(
  parameter int unsigned CAPACITY    = olist_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [olist_pkg::CMD_W-1:0]       command,
  input  wire logic signed [olist_pkg::IN_W-1:0] value,
  input  wire logic [olist_pkg::IDX_W-1:0]       index,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [olist_pkg::STAT_W-1:0]           status,
  output logic [olist_pkg::POS_W-1:0]            position,
  output logic [olist_pkg::COUNT_W-1:0]          entry_count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CW > olist_pkg::COUNT_W) ? CW : olist_pkg::COUNT_W;
  localparam int unsigned PW = (AW > olist_pkg::POS_W) ? AW : olist_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PLACE,
    S_RESP
  } state_t;

  state_t                  state;
  olist_pkg::cmd_t         cmd;
  olist_pkg::status_t      res_status;
  logic signed [VALUE_WIDTH-1:0] vreg;
  logic [CW-1:0]           count;
  logic [CW-1:0]           ptr;
  logic [AW-1:0]           pos;
  logic                    chk;
  logic [AW-1:0]           chk_addr;

  // list storage
  logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] rdata;
  logic [AW-1:0]           rd_addr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [VALUE_WIDTH-1:0] wdata;

  // input value widened by sign then held at the list width
  logic signed [63:0]      value_x;
  logic [IW-1:0]           idx_w;
  logic [IW-1:0]           cnt_w;
  logic [IW-1:0]           ins_pos;
  logic [CW-1:0]           ptr_m1;
  logic                    full;
  logic                    hit;
  logic                    out_free;
  logic [PW-1:0]           pos_ext;

  assign value_x  = 64'(value);
  assign idx_w    = IW'(index);
  assign cnt_w    = IW'(count);
  assign ins_pos  = (idx_w < cnt_w) ? idx_w : cnt_w;
  assign ptr_m1   = ptr - CW'(1);
  assign full     = (count == CW'(CAPACITY));
  assign out_free = !out_valid || out_ready;
  assign pos_ext  = PW'(pos);
  assign in_ready = (state == S_IDLE) && !rst;

  // shared compare unit: order test for sorted insert, equality otherwise
  always_comb begin
    if (cmd == olist_pkg::CMD_INSERT_SORTED) begin
      hit = (rdata >= vreg);
    end else begin
      hit = (rdata == vreg);
    end
  end

  // read address: walking up for scan and delete, down for insert
  always_comb begin
    if (state == S_SHIFT_UP) begin
      rd_addr = ptr_m1[AW-1:0];
    end else begin
      rd_addr = ptr[AW-1:0];
    end
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = vreg;
    if (state == S_SHIFT_UP && chk) begin
      we    = 1'b1;
      waddr = chk_addr + AW'(1);
      wdata = rdata;
    end else if (state == S_SHIFT_DN && chk) begin
      we    = 1'b1;
      waddr = chk_addr - AW'(1);
      wdata = rdata;
    end else if (state == S_PLACE) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd  <= olist_pkg::cmd_t'(command);
            vreg <= value_x[VALUE_WIDTH-1:0];
            chk  <= 1'b0;
            unique case (command) inside
              olist_pkg::CMD_PUSH_FRONT, olist_pkg::CMD_INSERT_AT: begin
                pos <= (command == olist_pkg::CMD_INSERT_AT) ? ins_pos[AW-1:0] : '0;
                if (full) begin
                  res_status <= olist_pkg::ST_FULL;
                  state      <= S_RESP;
                end else begin
                  res_status <= olist_pkg::ST_DONE;
                  ptr        <= count;
                  state      <= S_SHIFT_UP;
                end
              end
              olist_pkg::CMD_INSERT_SORTED: begin
                pos <= '0;
                if (full) begin
                  res_status <= olist_pkg::ST_FULL;
                  state      <= S_RESP;
                end else begin
                  res_status <= olist_pkg::ST_DONE;
                  ptr        <= '0;
                  state      <= S_SCAN;
                end
              end
              olist_pkg::CMD_DELETE, olist_pkg::CMD_SEARCH: begin
                res_status <= olist_pkg::ST_DONE;
                pos        <= '0;
                ptr        <= '0;
                state      <= S_SCAN;
              end
              olist_pkg::CMD_CLEAR: begin
                res_status <= olist_pkg::ST_DONE;
                pos        <= '0;
                count      <= '0;
                state      <= S_RESP;
              end
              default: begin
                res_status <= olist_pkg::ST_DONE;
                pos        <= '0;
                state      <= S_RESP;
              end
            endcase
          end
        end

        // walk the list one entry a cycle, checking the entry read last cycle
        S_SCAN: begin
          if (chk && hit) begin
            chk <= 1'b0;
            pos <= chk_addr;
            if (cmd == olist_pkg::CMD_INSERT_SORTED) begin
              ptr   <= count;
              state <= S_SHIFT_UP;
            end else if (cmd == olist_pkg::CMD_DELETE) begin
              ptr   <= CW'(chk_addr) + CW'(1);
              state <= S_SHIFT_DN;
            end else begin
              state <= S_RESP;
            end
          end else if (ptr < count) begin
            chk      <= 1'b1;
            chk_addr <= ptr[AW-1:0];
            ptr      <= ptr + CW'(1);
          end else begin
            chk <= 1'b0;
            if (cmd == olist_pkg::CMD_INSERT_SORTED) begin
              pos   <= count[AW-1:0];
              ptr   <= count;
              state <= S_SHIFT_UP;
            end else begin
              res_status <= olist_pkg::ST_MISS;
              state      <= S_RESP;
            end
          end
        end

        // open a gap at pos by moving entries up, top first
        S_SHIFT_UP: begin
          if (ptr > CW'(pos)) begin
            chk      <= 1'b1;
            chk_addr <= ptr_m1[AW-1:0];
            ptr      <= ptr_m1;
          end else begin
            chk   <= 1'b0;
            state <= S_PLACE;
          end
        end

        // close the gap at pos by moving entries down
        S_SHIFT_DN: begin
          if (ptr < count) begin
            chk      <= 1'b1;
            chk_addr <= ptr[AW-1:0];
            ptr      <= ptr + CW'(1);
          end else begin
            chk   <= 1'b0;
            count <= count - CW'(1);
            state <= S_RESP;
          end
        end

        S_PLACE: begin
          count <= count + CW'(1);
          state <= S_RESP;
        end

        // hand the result to the output register once it is free
        S_RESP: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            position    <= (res_status == olist_pkg::ST_DONE) ? pos_ext[olist_pkg::POS_W-1:0]
                                                             : '0;
            entry_count <= cnt_w[olist_pkg::COUNT_W-1:0];
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count stays within the list capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // placing a value grows the list by exactly one
  a_place_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_PLACE |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list by one");

  // moves while opening a gap stay inside the grown list
  a_shift_up_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_UP && chk) |-> CW'(chk_addr) < count && CW'(chk_addr) >= CW'(pos))
    else $error("upward move outside the list");

  // the scan never runs past the held entries
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ptr <= count)
    else $error("scan pointer beyond count");

  // no new request is taken while a command is still being worked on
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

endmodule

`default_nettype wire

>>> tb/tb_ordered_list_engine_top.sv
// tb_ordered_list_engine_top: self-checking bench for the ordered list engine
// drives list requests through valid/ready, predicts each result and compares field by field
// depends on olist_pkg and ordered_list_engine_top
`default_nettype none

module tb_ordered_list_engine_top;

  localparam int CAP            = int'(olist_pkg::CAPACITY_DEF);
  localparam int RAND_PER_PHASE = 570;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int DIR_ROWS       = 24;

  // command codes the block treats as no-ops
  localparam logic [olist_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [olist_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    olist_pkg::status_t            st;
    logic [olist_pkg::POS_W-1:0]   pos;
    logic [olist_pkg::COUNT_W-1:0] cnt;
  } list_result_t;

  typedef struct {
    logic [olist_pkg::CMD_W-1:0] cmd;
    logic [olist_pkg::IN_W-1:0]  val;
    logic [olist_pkg::IDX_W-1:0] idx;
    int                          reps;
    bit                          typed;
    list_result_t                want;
  } dir_row_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [olist_pkg::CMD_W-1:0]         command;
  logic signed [olist_pkg::IN_W-1:0]   value;
  logic [olist_pkg::IDX_W-1:0]         index;
  logic                                out_valid;
  logic                                out_ready;
  logic [olist_pkg::STAT_W-1:0]        status;
  logic [olist_pkg::POS_W-1:0]         position;
  logic [olist_pkg::COUNT_W-1:0]       entry_count;

  // predicted list contents
  logic signed [olist_pkg::IN_W-1:0]   list_vals [CAP];
  int                                  list_len;
  list_result_t                        pending_results [$];
  dir_row_t                            dir_rows [DIR_ROWS];

  int                                  mismatches   = 0;
  int                                  quiet_cycles = 0;
  int                                  cycle_no     = 0;
  int                                  tx_idle_pct;
  int                                  rx_idle_pct;
  bit                                  hold_request;
  bit                                  hold_done    = 1'b0;

  ordered_list_engine_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .value       (value),
    .index       (index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_no, msg);
    mismatches++;
  endtask

  // apply one request to the predicted list and return its result
  task automatic list_step(input logic [olist_pkg::CMD_W-1:0] cmd,
                           input logic signed [olist_pkg::IN_W-1:0] val,
                           input logic [olist_pkg::IDX_W-1:0] idx,
                           output list_result_t res);
    int at;
    res.st  = olist_pkg::ST_DONE;
    res.pos = '0;
    at      = 0;
    case (cmd) inside
      olist_pkg::CMD_PUSH_FRONT, olist_pkg::CMD_INSERT_AT, olist_pkg::CMD_INSERT_SORTED: begin
        if (list_len >= CAP) begin
          res.st = olist_pkg::ST_FULL;
        end else begin
          if (cmd == olist_pkg::CMD_INSERT_AT) begin
            at = (int'(idx) < list_len) ? int'(idx) : list_len;
          end else if (cmd == olist_pkg::CMD_INSERT_SORTED) begin
            // first entry not less than the new value, else the end
            at = list_len;
            for (int i = list_len - 1; i >= 0; i--)
              if (list_vals[i] >= val) at = i;
          end
          for (int i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = val;
          list_len++;
          res.pos = at[olist_pkg::POS_W-1:0];
        end
      end
      olist_pkg::CMD_DELETE, olist_pkg::CMD_SEARCH: begin
        at = list_len;
        for (int i = list_len - 1; i >= 0; i--)
          if (list_vals[i] == val) at = i;
        if (at == list_len) begin
          res.st = olist_pkg::ST_MISS;
        end else begin
          res.pos = at[olist_pkg::POS_W-1:0];
          if (cmd == olist_pkg::CMD_DELETE) begin
            for (int i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
            list_len--;
          end
        end
      end
      olist_pkg::CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    res.cnt = list_len[olist_pkg::COUNT_W-1:0];
  endtask

  // offer one request, wait for acceptance, then queue what it should produce
  task automatic send_request(input logic [olist_pkg::CMD_W-1:0] cmd,
                              input logic [olist_pkg::IN_W-1:0] val,
                              input logic [olist_pkg::IDX_W-1:0] idx, input bit typed,
                              input list_result_t want);
    list_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    index    <= idx;
    do @(posedge clk); while (!in_ready);
    list_step(cmd, val, idx, res);
    pending_results.push_back(typed ? want : res);
  endtask

  // small values in two of five picks for duplicates and hits, some extremes, rest full range
  function automatic logic [olist_pkg::IN_W-1:0] pick_value();
    int unsigned r;
    int          v;
    r = $urandom_range(99);
    if (r < 40) begin
      v = int'($urandom_range(16)) - 8;
      return v;
    end
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // wait until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side, random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    cycle_no <= cycle_no + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d position %0d count %0d",
                                  status, position, entry_count));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st)
          report_mismatch($sformatf("status got %0d want %0d", status, want.st));
        if (position !== want.pos)
          report_mismatch($sformatf("position got %0d want %0d", position, want.pos));
        if (entry_count !== want.cnt)
          report_mismatch($sformatf("entry_count got %0d want %0d", entry_count, want.cnt));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [olist_pkg::CMD_W-1:0] cmd;
    logic [olist_pkg::IN_W-1:0]  val;
    logic [olist_pkg::IDX_W-1:0] idx;
    int unsigned                 pick;
    int unsigned                 ins_w;
    list_result_t                none;

    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = '0;
    value        = '0;
    index        = '0;
    list_len     = 0;
    hold_request = 1'b0;
    tx_idle_pct  = 20;
    rx_idle_pct  = 74;
    none         = '{olist_pkg::ST_DONE, 4'd0, 5'd0};

    // directed requests: empty list, extremes, full list, no-op codes
    dir_rows[0]  = '{olist_pkg::CMD_SEARCH, 32'h0000_0000, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_MISS, 4'd0, 5'd0}};
    dir_rows[1]  = '{olist_pkg::CMD_DELETE, 32'h0000_0000, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_MISS, 4'd0, 5'd0}};
    dir_rows[2]  = '{CMD_RSVD6, 32'hffff_ffff, 5'd31, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd0}};
    dir_rows[3]  = '{CMD_RSVD7, 32'h0000_0000, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd0}};
    dir_rows[4]  = '{olist_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd1}};
    dir_rows[5]  = '{olist_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd2}};
    dir_rows[6]  = '{olist_pkg::CMD_INSERT_SORTED, 32'h0000_0000, 5'd0, 1, 1'b0, none};
    dir_rows[7]  = '{olist_pkg::CMD_INSERT_SORTED, 32'hffff_ffff, 5'd0, 1, 1'b0, none};
    dir_rows[8]  = '{olist_pkg::CMD_INSERT_AT, 32'h0000_0003, 5'd31, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd4, 5'd5}};
    dir_rows[9]  = '{olist_pkg::CMD_INSERT_AT, 32'h5555_5555, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd6}};
    dir_rows[10] = '{olist_pkg::CMD_INSERT_AT, 32'hffff_fffb, 5'd2, 1, 1'b0, none};
    dir_rows[11] = '{olist_pkg::CMD_INSERT_SORTED, 32'h7fff_ffff, 5'd0, 1, 1'b0, none};
    dir_rows[12] = '{olist_pkg::CMD_SEARCH, 32'h8000_0000, 5'd0, 1, 1'b0, none};
    dir_rows[13] = '{olist_pkg::CMD_DELETE, 32'h7fff_ffff, 5'd0, 1, 1'b0, none};
    dir_rows[14] = '{olist_pkg::CMD_INSERT_AT, 32'haaaa_aaaa, 5'd16, 1, 1'b0, none};
    dir_rows[15] = '{olist_pkg::CMD_SEARCH, 32'h0000_3039, 5'd0, 1, 1'b0, none};
    dir_rows[16] = '{olist_pkg::CMD_CLEAR, 32'h0000_0000, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd0}};
    dir_rows[17] = '{olist_pkg::CMD_PUSH_FRONT, 32'h0000_002a, 5'd0, 16, 1'b0, none};
    dir_rows[18] = '{olist_pkg::CMD_INSERT_AT, 32'h0000_0001, 5'd5, 1, 1'b1,
                     '{olist_pkg::ST_FULL, 4'd0, 5'd16}};
    dir_rows[19] = '{olist_pkg::CMD_INSERT_SORTED, 32'h0000_0001, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_FULL, 4'd0, 5'd16}};
    dir_rows[20] = '{olist_pkg::CMD_PUSH_FRONT, 32'h0000_0001, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_FULL, 4'd0, 5'd16}};
    dir_rows[21] = '{olist_pkg::CMD_SEARCH, 32'h0000_002a, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd16}};
    dir_rows[22] = '{olist_pkg::CMD_DELETE, 32'h0000_002a, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd15}};
    dir_rows[23] = '{olist_pkg::CMD_CLEAR, 32'h0000_0000, 5'd0, 1, 1'b1,
                     '{olist_pkg::ST_DONE, 4'd0, 5'd0}};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      repeat (dir_rows[r].reps)
        send_request(dir_rows[r].cmd, dir_rows[r].val, dir_rows[r].idx,
                     dir_rows[r].typed, dir_rows[r].want);
    drain_results();

    // random requests in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 74 : 0;
      rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 20 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // long result-side hold-off while requests keep coming
        if (phase == 2 && n == 200) hold_request = 1'b1;
        ins_w = (list_len >= 12) ? 35 : 60;
        pick  = $urandom_range(99);
        idx   = 5'($urandom_range(31));
        val   = pick_value();
        if (pick < ins_w) begin
          case ($urandom_range(2))
            0: cmd = olist_pkg::CMD_PUSH_FRONT;
            1: begin
              cmd = olist_pkg::CMD_INSERT_AT;
              if ($urandom_range(1) == 1) idx = 5'($urandom_range(list_len));
            end
            default: cmd = olist_pkg::CMD_INSERT_SORTED;
          endcase
        end else if (pick < 96) begin
          cmd = ($urandom_range(1) == 1) ? olist_pkg::CMD_DELETE : olist_pkg::CMD_SEARCH;
          // mostly look for values that are held
          if (list_len > 0 && $urandom_range(99) < 65)
            val = list_vals[$urandom_range(list_len - 1)];
        end else if (pick < 98) begin
          cmd = olist_pkg::CMD_CLEAR;
        end else begin
          cmd = ($urandom_range(1) == 1) ? CMD_RSVD7 : CMD_RSVD6;
        end
        send_request(cmd, val, idx, 1'b0, none);
      end
      // sender pauses until the block has answered everything
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
